// File: hdl/bfal_pkg.sv
// Shared types, sizes and helpers for the bounded frequency admission list.
// No dependencies; imported by every module of the block.
package bfal_pkg;

  // Storage sizes
  localparam int DEPTH      = 64;
  localparam int COUNT_BITS = 16;

  // Fixed field widths of the item ports
  localparam int KEY_W    = 32;
  localparam int START_W  = 16;
  localparam int POS_W    = 6;
  localparam int OCNT_W   = 16;
  localparam int FILL_W   = 7;
  localparam int LIMIT_W  = 7;
  localparam int HOT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived internal widths
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int FILL_BITS = $clog2(DEPTH + 1);
  localparam int LIM_CMP_W = (FILL_BITS > LIMIT_W) ? FILL_BITS : LIMIT_W;
  localparam int CNT_CMP_W = (COUNT_BITS > START_W) ? COUNT_BITS : START_W;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESHOLD = 2'd1;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 7'd64;
  localparam logic [HOT_W-1:0]     HOT_RESET   = 16'd1;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [FILL_BITS-1:0]  fill_t;

  localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

  // One stored pair with its hit count
  typedef struct packed {
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    cnt_t             count;
  } entry_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic load_match;  // compare incoming pair, latch match flag
    logic shift;       // move every entry back one place
    logic bump;        // matching cell counts one more hit
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Saturating increment of a hit count
  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c == CNT_MAX) ? c : c + cnt_t'(1);
  endfunction

endpackage

// File: hdl/bfal_cell.sv
// One position of the list: a stored pair, its count and a latched match flag.
// Depends on bfal_pkg.
module bfal_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  bfal_pkg::cell_ctrl_t        ctrl,
  input  logic                        valid,
  input  logic [bfal_pkg::KEY_W-1:0]  cmp_a,
  input  logic [bfal_pkg::KEY_W-1:0]  cmp_b,
  input  bfal_pkg::entry_t            prev,
  output bfal_pkg::entry_t            entry,
  output logic                        match
);
  import bfal_pkg::*;

  // Match flag, only for entries inside the fill
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.load_match) begin
      match <= valid && (entry.key_a == cmp_a) && (entry.key_b == cmp_b);
    end
  end

  // Entry: shift from the neighbor in front, or count a hit
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= prev;
    end else if (ctrl.bump && match) begin
      entry.count <= sat_inc(entry.count);
    end
  end

endmodule

// File: hdl/bfal_pick.sv
// Encodes the one-hot match row into a position and selects the matching count.
// Depends on bfal_pkg.
module bfal_pick (
  input  logic [bfal_pkg::DEPTH-1:0] match,
  input  bfal_pkg::cnt_t             counts [bfal_pkg::DEPTH],
  output logic                       hit,
  output bfal_pkg::idx_t             index,
  output bfal_pkg::cnt_t             count
);
  import bfal_pkg::*;

  // Keys are unique in the list, so at most one bit is set: plain OR trees
  always_comb begin
    index = '0;
    count = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        index = index | idx_t'(i);
        count = count | counts[i];
      end
    end
  end

  assign hit = |match;

endmodule

// File: hdl/bounded_frequency_admission_list.sv
// Bounded frequency admission list: a row of DEPTH cells, newest pair at the
// front, each with a saturating hit count. An item is handled in two steps: at the
// accepting edge every cell compares its pair against the input and latches a
// match flag; in the update state the match row is encoded, the hit count is
// bumped in place or, on a miss, the whole row shifts back one cell and the
// new pair enters cell 0, and the result is loaded into the output register.
// No new item is taken during the update or while a result is held stalled. The
// stores need no clearing after reset: an entry counts only below the fill.
// Depends on bfal_pkg, bfal_cell and bfal_pick.
module bounded_frequency_admission_list (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [bfal_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfal_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bfal_pkg::KEY_W-1:0]       key_a,
  input  logic [bfal_pkg::KEY_W-1:0]       key_b,
  input  logic [bfal_pkg::START_W-1:0]     start_count,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             was_hit,
  output logic [bfal_pkg::POS_W-1:0]       position,
  output logic [bfal_pkg::OCNT_W-1:0]      count_now,
  output logic                             is_hot,
  output logic                             did_evict,
  output logic [bfal_pkg::FILL_W-1:0]      fill
);
  import bfal_pkg::*;

  state_t                state, state_next;
  cell_ctrl_t            ctrl;
  logic                  accept;
  logic                  update;

  logic [LIMIT_W-1:0]    length_limit;
  logic [HOT_W-1:0]      hot_threshold;
  fill_t                 fill_cnt, fill_cnt_next;

  logic [KEY_W-1:0]      key_a_q, key_b_q;
  logic [START_W-1:0]    start_q;
  cnt_t                  start_sat;

  entry_t                chain [DEPTH];
  entry_t                front;
  cnt_t                  counts [DEPTH];
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      valid;

  logic                  hit;
  idx_t                  hit_index;
  cnt_t                  hit_count;
  cnt_t                  count_new;
  logic [LIM_CMP_W-1:0]  limit_eff;
  logic                  evict;

  assign accept = in_valid && !in_stall;
  assign update = (state == ST_UPDATE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit  <= LIMIT_RESET;
      hot_threshold <= HOT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LENGTH_LIMIT:  length_limit  <= cfg_data[LIMIT_W-1:0];
        REG_HOT_THRESHOLD: hot_threshold <= cfg_data[HOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    case (state)
      ST_IDLE:   state_next = accept ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: outputs
  always_comb begin
    in_stall        = 1'b1;
    ctrl.load_match = 1'b0;
    ctrl.shift      = 1'b0;
    ctrl.bump       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall        = out_valid && out_stall;
        ctrl.load_match = in_valid && !in_stall;
      end
      ST_UPDATE: begin
        ctrl.shift = !hit;
        ctrl.bump  = hit;
      end
      default: ;
    endcase
  end

  // Hold the accepted item for the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      key_a_q <= key_a;
      key_b_q <= key_b;
      start_q <= start_count;
    end
  end

  // Starting count, saturated to the counter range
  assign start_sat = (CNT_CMP_W'(start_q) > CNT_CMP_W'(CNT_MAX)) ? CNT_MAX
                                                                  : cnt_t'(start_q);

  assign front.key_a = key_a_q;
  assign front.key_b = key_b_q;
  assign front.count = start_sat;

  // Row of cells; cell 0 takes the new pair
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam fill_t POS = fill_t'(i);
    assign valid[i]  = POS < fill_cnt;
    assign counts[i] = chain[i].count;

    if (i == 0) begin : g_head
      bfal_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .valid (valid[i]),
        .cmp_a (key_a),
        .cmp_b (key_b),
        .prev  (front),
        .entry (chain[i]),
        .match (match[i])
      );
    end else begin : g_body
      bfal_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .valid (valid[i]),
        .cmp_a (key_a),
        .cmp_b (key_b),
        .prev  (chain[i-1]),
        .entry (chain[i]),
        .match (match[i])
      );
    end
  end

  bfal_pick u_pick (
    .match  (match),
    .counts (counts),
    .hit    (hit),
    .index  (hit_index),
    .count  (hit_count)
  );

  // Length limit clamped to one..DEPTH
  always_comb begin
    if (length_limit == '0) begin
      limit_eff = LIM_CMP_W'(1);
    end else if (LIM_CMP_W'(length_limit) > LIM_CMP_W'(DEPTH)) begin
      limit_eff = LIM_CMP_W'(DEPTH);
    end else begin
      limit_eff = LIM_CMP_W'(length_limit);
    end
  end

  // A miss at or past the limit drops the tail; fill then stays put
  assign evict     = !hit && (LIM_CMP_W'(fill_cnt) >= limit_eff);
  assign count_new = hit ? sat_inc(hit_count) : start_sat;

  always_comb begin
    fill_cnt_next = fill_cnt;
    if (update && !hit && !evict) begin
      fill_cnt_next = fill_cnt + fill_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else begin
      fill_cnt <= fill_cnt_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (update) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      was_hit   <= hit;
      position  <= hit ? POS_W'(hit_index) : '0;
      count_now <= OCNT_W'(count_new);
      is_hot    <= CNT_CMP_W'(count_new) >= CNT_CMP_W'(hot_threshold);
      did_evict <= evict;
      fill      <= FILL_W'(fill_cnt_next);
    end
  end

endmodule
